/* sv/hrp_pkg.sv */
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared constants and key tables for the HTTP request header parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam int PATH_CAP    = 256;
  localparam int TYPE_CAP    = 128;
  localparam int MAX_REQUEST = 65535;

  localparam int PC_W = $clog2(PATH_CAP + 1);
  localparam int TC_W = $clog2(TYPE_CAP);
  localparam int RX_W = $clog2(MAX_REQUEST + 1);

  localparam logic [PC_W-1:0] PATH_LIM  = PC_W'(PATH_CAP);
  localparam logic [PC_W-1:0] PATH_LIM1 = PC_W'(PATH_CAP - 1);
  localparam logic [TC_W-1:0] TYPE_LIM1 = TC_W'(TYPE_CAP - 1);
  localparam logic [RX_W-1:0] RX_LIM    = RX_W'(MAX_REQUEST);

  localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

  localparam logic [2:0] KIND_PATH  = 3'd0;
  localparam logic [2:0] KIND_TREST = 3'd1;
  localparam logic [2:0] KIND_TYPE  = 3'd2;
  localparam logic [2:0] KIND_BODY  = 3'd3;
  localparam logic [2:0] KIND_SUM   = 3'd4;

  localparam logic [1:0] METH_GET  = 2'd0;
  localparam logic [1:0] METH_POST = 2'd1;
  localparam logic [1:0] METH_UNK  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  function automatic logic [7:0] get_key(input logic [4:0] p);
    case (p)
      5'd0:    get_key = "G";
      5'd1:    get_key = "E";
      default: get_key = "T";
    endcase
  endfunction

  function automatic logic [7:0] post_key(input logic [4:0] p);
    case (p)
      5'd0:    post_key = "P";
      5'd1:    post_key = "O";
      5'd2:    post_key = "S";
      default: post_key = "T";
    endcase
  endfunction

  function automatic logic [7:0] type_key(input logic [4:0] p);
    case (p)
      5'd0:    type_key = "c";
      5'd1:    type_key = "o";
      5'd2:    type_key = "n";
      5'd3:    type_key = "t";
      5'd4:    type_key = "e";
      5'd5:    type_key = "n";
      5'd6:    type_key = "t";
      5'd7:    type_key = "-";
      5'd8:    type_key = "t";
      5'd9:    type_key = "y";
      5'd10:   type_key = "p";
      5'd11:   type_key = "e";
      default: type_key = ":";
    endcase
  endfunction

  function automatic logic [7:0] len_key(input logic [4:0] p);
    case (p)
      5'd0:    len_key = "c";
      5'd1:    len_key = "o";
      5'd2:    len_key = "n";
      5'd3:    len_key = "t";
      5'd4:    len_key = "e";
      5'd5:    len_key = "n";
      5'd6:    len_key = "t";
      5'd7:    len_key = "-";
      5'd8:    len_key = "l";
      5'd9:    len_key = "e";
      5'd10:   len_key = "n";
      5'd11:   len_key = "g";
      5'd12:   len_key = "t";
      5'd13:   len_key = "h";
      default: len_key = ":";
    endcase
  endfunction

endpackage

/* sv/http_request_header_parser_top.sv */
// Each input byte is registered in the input register; its results are registered in the result queue.
// Throughput: one byte per cycle while out_stall is low and each byte yields at
// most one result; a byte yielding k results fills the 3-entry result queue and stalls input while they drain.
// Reset (synchronous, rst_n low) returns the parser to the request line
// and empties the input register and the result queue.
// ----------------------------------------------------------------------------
// http_request_header_parser_top
// Byte-serial HTTP/1.1 request parser: method, path, content type, length,
// body bytes and an end-of-buffer summary.
// ----------------------------------------------------------------------------
module http_request_header_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_method_code,
  output logic        out_path_valid,
  output logic [7:0]  out_path_length,
  output logic [30:0] out_body_length,
  output logic [15:0] out_body_count,
  output logic        out_last_result
);
  import hrp_pkg::*;

  typedef enum logic [2:0] {
    PH_REQ, PH_HDR, PH_TSKIP, PH_TVAL, PH_LVAL, PH_BODY, PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {NUM_IDLE, NUM_WS, NUM_DIG, NUM_DONE} num_t;

  localparam logic [2:0] MS_GET  = 3'd4;
  localparam logic [2:0] MS_POST = 3'd5;

  typedef struct packed {
    phase_t            phase;
    logic [4:0]        lpos;
    logic [2:0]        ms;
    logic [1:0]        sc;
    logic [PC_W-1:0]   pc;
    logic              pok;
    logic [1:0]        hm;
    logic [TC_W-1:0]   tc;
    num_t              ns;
    logic [30:0]       len;
    logic              crp;
    logic [15:0]       bc;
    logic              stopped;
    logic [RX_W-1:0]   rx;
  } st_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [1:0]  meth;
    logic        pv;
    logic [7:0]  plen;
    logic [30:0] blen;
    logic [15:0] bcnt;
    logic        last;
  } res_t;

  typedef struct packed {
    st_t        s;
    logic       e;
    logic [2:0] k;
  } dres_t;

  function automatic st_t st_reset();
    st_t s;
    s         = '0;
    s.phase   = PH_REQ;
    s.ms      = 3'd3;
    s.hm      = 2'd3;
    s.ns      = NUM_IDLE;
    return s;
  endfunction

  function automatic res_t mk_res(input st_t s, input logic [2:0] k, input logic [7:0] b);
    res_t r;
    r      = '0;
    r.kind = k;
    r.data = b;
    if (k == KIND_SUM) begin
      r.meth = (s.ms == MS_GET) ? METH_GET : ((s.ms == MS_POST) ? METH_POST : METH_UNK);
      r.pv   = s.pok;
      r.plen = s.pok ? 8'(s.pc) : 8'd0;
      r.blen = (s.phase == PH_BODY) ? s.len : 31'd0;
      r.bcnt = s.bc;
    end
    return r;
  endfunction

  function automatic st_t decide_body(input st_t si);
    st_t s;
    s       = si;
    s.phase = (s.ms == MS_POST && s.len != 31'd0) ? PH_BODY : PH_IDLE;
    return s;
  endfunction

  function automatic dres_t data_step(input st_t si, input logic [7:0] c);
    dres_t      d;
    logic [4:0] p;
    logic [7:0] lc;
    logic       ws;
    logic       dig;
    logic       acc;
    logic       hit;
    logic [34:0] t;
    d   = '0;
    d.s = si;
    p   = si.lpos;
    acc = 1'b0;
    hit = 1'b0;
    t   = '0;
    lc  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    ws  = c == CH_SPACE || c == 8'h09 || c == CH_LF || c == 8'h0B || c == 8'h0C || c == CH_CR;
    dig = c >= "0" && c <= "9";
    if (si.lpos != 5'd31) d.s.lpos = si.lpos + 5'd1;
    case (si.phase)
      PH_REQ: begin
        if (d.s.ms < 3'd4) begin
          if (d.s.ms[0] && p < 5'd3) begin
            if (c != get_key(p)) d.s.ms[0] = 1'b0;
            else if (p == 5'd2) d.s.ms = MS_GET;
          end
          if (d.s.ms < 3'd4 && d.s.ms[1] && p < 5'd4) begin
            if (c != post_key(p)) d.s.ms[1] = 1'b0;
            else if (p == 5'd3) d.s.ms = MS_POST;
          end
        end
        if (si.sc == 2'd0) begin
          if (c == CH_SPACE) d.s.sc = 2'd1;
        end else if (si.sc == 2'd1) begin
          if (c == CH_SPACE) begin
            d.s.sc  = 2'd2;
            d.s.pok = si.pc < PATH_LIM;
          end else begin
            if (si.pc < PATH_LIM1) begin
              d.e = 1'b1;
              d.k = KIND_PATH;
            end
            if (si.pc < PATH_LIM) d.s.pc = si.pc + 1'b1;
          end
        end
      end
      PH_HDR: begin
        if (si.hm[0] && p < 5'd13) begin
          if (lc != type_key(p)) d.s.hm[0] = 1'b0;
          else if (p == 5'd12) begin
            d.s.hm    = 2'd0;
            d.s.tc    = '0;
            d.s.phase = PH_TSKIP;
            d.e       = 1'b1;
            d.k       = KIND_TREST;
            hit       = 1'b1;
          end
        end
        if (!hit && d.s.hm[1] && p < 5'd15) begin
          if (lc != len_key(p)) d.s.hm[1] = 1'b0;
          else if (p == 5'd14) begin
            d.s.hm    = 2'd0;
            d.s.len   = '0;
            d.s.ns    = NUM_WS;
            d.s.phase = PH_LVAL;
          end
        end
      end
      PH_TSKIP, PH_TVAL: begin
        if (si.phase == PH_TVAL || c != CH_SPACE) begin
          d.s.phase = PH_TVAL;
          if (si.tc < TYPE_LIM1) begin
            d.e    = 1'b1;
            d.k    = KIND_TYPE;
            d.s.tc = si.tc + 1'b1;
          end
        end
      end
      PH_LVAL: begin
        if (si.ns == NUM_WS) begin
          if (ws) begin
          end else if (c == CH_PLUS) begin
            d.s.ns = NUM_DIG;
          end else if (!dig) begin
            d.s.ns = NUM_DONE;
          end else begin
            d.s.ns = NUM_DIG;
            acc    = 1'b1;
          end
        end else if (si.ns == NUM_DIG) begin
          if (!dig) d.s.ns = NUM_DONE;
          else acc = 1'b1;
        end
        if (acc) begin
          t = ({4'd0, si.len} << 3) + ({4'd0, si.len} << 1) + {31'd0, 4'(c - "0")};
          d.s.len = (t > {4'd0, LEN_MAX}) ? LEN_MAX : t[30:0];
        end
      end
      default: begin
      end
    endcase
    return d;
  endfunction

  st_t        st_r, st_nxt;
  logic       iv_r;
  logic [7:0] ib_r;
  logic       ie_r;
  res_t       q_r [3];
  res_t       r_nxt [3];
  logic [1:0] qn_r;
  logic [1:0] n_nxt;
  logic       take;
  logic       can_load;
  logic       go;

  assign take     = (qn_r != 2'd0) && !out_stall;
  assign can_load = (qn_r == 2'd0) || (qn_r == 2'd1 && take);
  assign go       = iv_r && can_load;
  assign in_stall = iv_r && !can_load;

  always_comb begin
    st_t   s;
    dres_t d;
    logic  done;
    s    = st_r;
    d    = '0;
    done = 1'b0;
    n_nxt = 2'd0;
    for (int i = 0; i < 3; i++) r_nxt[i] = '0;
    if (!s.stopped && s.rx < RX_LIM) begin
      s.rx = s.rx + 1'b1;
      if (s.phase == PH_BODY) begin
        if (ib_r == CH_NUL) s.stopped = 1'b1;
        else if ({15'd0, s.bc} < s.len) begin
          r_nxt[n_nxt] = mk_res(s, KIND_BODY, ib_r);
          n_nxt        = n_nxt + 2'd1;
          s.bc         = s.bc + 16'd1;
        end
      end else if (s.phase == PH_IDLE) begin
        if (ib_r == CH_NUL) s.stopped = 1'b1;
      end else begin
        if (s.crp) begin
          s.crp = 1'b0;
          if (ib_r == CH_LF) begin
            done = 1'b1;
            if (s.phase == PH_HDR && s.lpos == 5'd0) s = decide_body(s);
            else begin
              s.phase = PH_HDR;
              s.lpos  = '0;
              s.hm    = 2'd3;
              s.ns    = NUM_IDLE;
            end
          end else begin
            d = data_step(s, CH_CR);
            s = d.s;
            if (d.e) begin
              r_nxt[n_nxt] = mk_res(s, d.k, (d.k == KIND_TREST) ? 8'd0 : CH_CR);
              n_nxt        = n_nxt + 2'd1;
            end
          end
        end
        if (!done) begin
          if (ib_r == CH_NUL) begin
            s.stopped = 1'b1;
            if (s.phase == PH_HDR && s.lpos == 5'd0) s = decide_body(s);
          end else if (ib_r == CH_CR) begin
            s.crp = 1'b1;
          end else begin
            d = data_step(s, ib_r);
            s = d.s;
            if (d.e) begin
              r_nxt[n_nxt] = mk_res(s, d.k, (d.k == KIND_TREST) ? 8'd0 : ib_r);
              n_nxt        = n_nxt + 2'd1;
            end
          end
        end
      end
    end
    if (ie_r) begin
      if (!s.stopped) begin
        if (s.crp && s.phase <= PH_LVAL) begin
          s.crp = 1'b0;
          d     = data_step(s, CH_CR);
          s     = d.s;
          if (d.e) begin
            r_nxt[n_nxt] = mk_res(s, d.k, (d.k == KIND_TREST) ? 8'd0 : CH_CR);
            n_nxt        = n_nxt + 2'd1;
          end
        end
        if (s.phase == PH_HDR && s.lpos == 5'd0) s = decide_body(s);
      end
      r_nxt[n_nxt] = mk_res(s, KIND_SUM, 8'd0);
      n_nxt        = n_nxt + 2'd1;
      s            = st_reset();
    end
    if (n_nxt != 2'd0) r_nxt[n_nxt - 2'd1].last = 1'b1;
    st_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_reset();
      iv_r <= 1'b0;
      qn_r <= 2'd0;
    end else begin
      if (in_valid && !in_stall) begin
        iv_r <= 1'b1;
        ib_r <= in_byte_in;
        ie_r <= in_buffer_end;
      end else if (go) begin
        iv_r <= 1'b0;
      end
      if (go) begin
        st_r <= st_nxt;
        q_r  <= r_nxt;
        qn_r <= n_nxt;
      end else if (take) begin
        q_r[0] <= q_r[1];
        q_r[1] <= q_r[2];
        qn_r   <= qn_r - 2'd1;
      end
    end
  end

  assign out_valid       = qn_r != 2'd0;
  assign out_kind        = q_r[0].kind;
  assign out_data_byte   = q_r[0].data;
  assign out_method_code = q_r[0].meth;
  assign out_path_valid  = q_r[0].pv;
  assign out_path_length = q_r[0].plen;
  assign out_body_length = q_r[0].blen;
  assign out_body_count  = q_r[0].bcnt;
  assign out_last_result = q_r[0].last;

endmodule
